// ===== hdl/gradient_noise_2d_core_defines.svh =====
// Assertion macros for the gradient noise core.
// No dependencies; included by the top level.
`ifndef GRADIENT_NOISE_2D_CORE_DEFINES_SVH
`define GRADIENT_NOISE_2D_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock, off while in reset.
`define GN2D_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock, off while in reset.
`define GN2D_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gn2d_pkg.sv =====
// Types, constants and datapath functions of the gradient noise core.
// No dependencies; used by gradient_noise_2d_core.
package gn2d_pkg;

    localparam int CS_W    = 13;
    localparam int PIX_W   = 12;
    localparam int FRAC_W  = 16;
    localparam int DIV_W   = PIX_W + FRAC_W;
    localparam int GRAD_W  = 16;
    localparam int ENTRY_W = 2 * GRAD_W;
    localparam int OFS_W   = FRAC_W + 1;
    localparam int DOT_W   = 34;
    localparam int DIFF_W  = DOT_W + 1;
    localparam int PROD_W  = DIFF_W + FRAC_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int TT_W    = 2 * FRAC_W;
    localparam int S_W     = FRAC_W + 2;
    localparam int OUT_W   = 16;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // 3.0 in Q.16
    localparam logic [S_W-1:0] THREE_Q16 = S_W'(3 * 65536);

    typedef struct packed {
        logic                     mode;
        logic [5:0]               grid_col;
        logic [5:0]               grid_row;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [PIX_W-1:0]         pixel_x;
        logic [PIX_W-1:0]         pixel_y;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] noise_value;
        logic             out_of_grid;
    } t_out;

    // partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [CS_W-1:0]  rem;
        logic [DIV_W-1:0] dq;
    } t_div;

    // one restoring division step
    function automatic t_div gn2d_div_step(input t_div st, input logic [CS_W-1:0] cs);
        logic [CS_W:0] tr;
        t_div          nx;
        tr = {st.rem, st.dq[DIV_W-1]};
        if (tr >= {1'b0, cs}) begin
            nx.rem = CS_W'(tr - {1'b0, cs});
            nx.dq  = {st.dq[DIV_W-2:0], 1'b1};
        end else begin
            nx.rem = tr[CS_W-1:0];
            nx.dq  = {st.dq[DIV_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    // gradient entry dotted with the corner offset, exact Q.30
    function automatic logic signed [DOT_W-1:0] gn2d_dot(
        input logic [ENTRY_W-1:0]     e,
        input logic signed [OFS_W-1:0] ox,
        input logic signed [OFS_W-1:0] oy
    );
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        gx = $signed(e[GRAD_W-1:0]);
        gy = $signed(e[ENTRY_W-1:GRAD_W]);
        return DOT_W'(gx * ox) + DOT_W'(gy * oy);
    endfunction

    // u = floor(t*t*(3-2t)), second half of the product
    function automatic logic [FRAC_W-1:0] gn2d_weight(
        input logic [TT_W-1:0] tt,
        input logic [S_W-1:0]  s
    );
        logic [TT_W+S_W-1:0] p;
        p = (TT_W+S_W)'(tt) * (TT_W+S_W)'(s);
        return p[TT_W+FRAC_W-1:TT_W];
    endfunction

    // (b-a)*u of a blend
    function automatic logic signed [PROD_W-1:0] gn2d_bmul(
        input logic signed [DOT_W-1:0] a,
        input logic signed [DOT_W-1:0] b,
        input logic [FRAC_W-1:0]       u
    );
        logic signed [DIFF_W-1:0] d;
        logic signed [FRAC_W:0]   us;
        d  = DIFF_W'(b) - DIFF_W'(a);
        us = $signed({1'b0, u});
        return PROD_W'(d * us);
    endfunction

    // floor((a<<16 + m) / 2^16)
    function automatic logic signed [DOT_W-1:0] gn2d_bsum(
        input logic signed [DOT_W-1:0]  a,
        input logic signed [PROD_W-1:0] m
    );
        logic signed [SUM_W-1:0] s;
        s = (SUM_W'(a) <<< FRAC_W) + SUM_W'(m);
        return DOT_W'(s >>> FRAC_W);
    endfunction

    // 0.5*v+0.5 in Q0.16, saturated
    function automatic t_out gn2d_result(input logic signed [DOT_W-1:0] v, input logic oog);
        logic signed [DOT_W-16:0] sh;
        logic signed [DOT_W-14:0] r;
        t_out                     o;
        sh = (DOT_W-15)'(v >>> 15);
        r  = (DOT_W-13)'(sh) + (DOT_W-13)'(32768);
        o.out_of_grid = oog;
        if (oog) begin
            o.noise_value = '0;
        end else if (r < 0) begin
            o.noise_value = '0;
        end else if (r > (DOT_W-13)'(65535)) begin
            o.noise_value = '1;
        end else begin
            o.noise_value = r[OUT_W-1:0];
        end
        return o;
    endfunction

endpackage

// ===== hdl/gn2d_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module gn2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== hdl/gradient_noise_2d_core.sv =====
// Top level of the 2-D gradient noise core: divider pipeline, gradient RAMs, blend.
// Depends on gn2d_pkg, gn2d_ram and gradient_noise_2d_core_defines.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (gn2d_pkg::t_in)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (gn2d_pkg::t_out)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_data (cell_size)
//
// Throughput: one transaction per cycle while the skid register is empty. An accepted
// transaction passes the input register, 28 restoring-divider steps, the RAM read, dots and
// weights, two x-blend stages and two y-blend stages, then reaches the output register.
// Reset (i_rst_n low, synchronous) clears the valid bits and sets cell_size to 1;
// the gradient RAMs keep their contents and are not cleared.
// A skid register behind the output register absorbs one result when the sink
// stalls; while it is full the whole pipeline holds and o_in_ready is low.
`include "gradient_noise_2d_core_defines.svh"

module gradient_noise_2d_core #(
    parameter int GRID_COLS  = 64,
    parameter int GRID_ROWS  = 64,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  gn2d_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output gn2d_pkg::t_out               o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gn2d_pkg::CS_W-1:0]    i_cfg_data
);

    // Gradients are banked by column parity: each bank serves the left or the
    // right corner pair, rows iy and iy+1 on its two read ports.
    localparam int HCOLS = (GRID_COLS + 1) / 2;
    localparam int DEPTH = GRID_ROWS * HCOLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NDIV  = gn2d_pkg::DIV_W;

    // ---------------- config ----------------
    logic [gn2d_pkg::CS_W-1:0] r_cs;
    logic [gn2d_pkg::CS_W-1:0] cs_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs <= gn2d_pkg::CS_W'(1);
        end else if (i_cfg_valid) begin
            r_cs <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cs_eff      = (r_cs == '0) ? gn2d_pkg::CS_W'(1) : r_cs;

    // ---------------- flow control ----------------
    logic r_ov;
    logic r_skv;
    logic adv;
    logic accept;

    assign adv        = !r_skv;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    // ---------------- divider pipeline ----------------
    // Stage 0 is the input register; stage k+1 is one quotient bit further.
    // Dividend is {pixel, 16 zero bits}: top quotient bits are the cell index,
    // low 16 bits the Q0.16 fraction.
    logic           r_dv  [NDIV+1];
    gn2d_pkg::t_in  r_din [NDIV+1];
    logic           r_rng [NDIV+1];
    gn2d_pkg::t_div r_dx  [NDIV+1];
    gn2d_pkg::t_div r_dy  [NDIV+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NDIV; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_dv[0] <= accept;
            for (int k = 0; k < NDIV; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_din[0]   <= i_in_data;
            r_rng[0]   <= (32'(i_in_data.pixel_x) >= MAX_WIDTH) ||
                          (32'(i_in_data.pixel_y) >= MAX_HEIGHT);
            r_dx[0].rem <= '0;
            r_dx[0].dq  <= {i_in_data.pixel_x, gn2d_pkg::FRAC_W'(0)};
            r_dy[0].rem <= '0;
            r_dy[0].dq  <= {i_in_data.pixel_y, gn2d_pkg::FRAC_W'(0)};
            for (int k = 0; k < NDIV; k++) begin
                r_din[k+1] <= r_din[k];
                r_rng[k+1] <= r_rng[k];
                r_dx[k+1]  <= gn2d_pkg::gn2d_div_step(r_dx[k], cs_eff);
                r_dy[k+1]  <= gn2d_pkg::gn2d_div_step(r_dy[k], cs_eff);
            end
        end
    end

    // ---------------- gradient RAM access ----------------
    // Writes are applied here, in order with the reads, so a pixel that entered
    // before a write never sees it and one that entered after always does.
    gn2d_pkg::t_in             d_in;
    logic [gn2d_pkg::PIX_W-1:0] ix;
    logic [gn2d_pkg::PIX_W-1:0] iy;
    logic                      d_oog;
    logic                      wr_ok;
    logic [AW-1:0]             waddr;
    logic [gn2d_pkg::ENTRY_W-1:0] wdata;
    logic [gn2d_pkg::PIX_W:0]  c_even;
    logic [gn2d_pkg::PIX_W:0]  c_odd;
    logic [gn2d_pkg::PIX_W:0]  row0;
    logic [gn2d_pkg::PIX_W:0]  row1;
    logic [AW-1:0]             ra_even0;
    logic [AW-1:0]             ra_even1;
    logic [AW-1:0]             ra_odd0;
    logic [AW-1:0]             ra_odd1;
    logic [gn2d_pkg::ENTRY_W-1:0] ev0;
    logic [gn2d_pkg::ENTRY_W-1:0] ev1;
    logic [gn2d_pkg::ENTRY_W-1:0] od0;
    logic [gn2d_pkg::ENTRY_W-1:0] od1;

    assign d_in  = r_din[NDIV];
    assign ix    = r_dx[NDIV].dq[gn2d_pkg::DIV_W-1:gn2d_pkg::FRAC_W];
    assign iy    = r_dy[NDIV].dq[gn2d_pkg::DIV_W-1:gn2d_pkg::FRAC_W];
    assign d_oog = r_rng[NDIV] || (32'(ix) + 32'(1) >= GRID_COLS) ||
                   (32'(iy) + 32'(1) >= GRID_ROWS);

    assign wr_ok = r_dv[NDIV] && (d_in.mode == gn2d_pkg::MODE_WRITE) &&
                   (32'(d_in.grid_col) < GRID_COLS) && (32'(d_in.grid_row) < GRID_ROWS);
    assign waddr = AW'(32'(d_in.grid_row) * HCOLS + 32'(d_in.grid_col >> 1));
    assign wdata = {d_in.grad_y, d_in.grad_x};

    // even bank holds column (ix+1)>>1 of the pair, odd bank column ix>>1
    assign c_even = d_oog ? '0 : ({1'b0, ix} + 13'd1) >> 1;
    assign c_odd  = d_oog ? '0 : {1'b0, ix} >> 1;
    assign row0   = d_oog ? '0 : {1'b0, iy};
    assign row1   = d_oog ? '0 : {1'b0, iy} + 13'd1;

    assign ra_even0 = AW'(32'(row0) * HCOLS + 32'(c_even));
    assign ra_even1 = AW'(32'(row1) * HCOLS + 32'(c_even));
    assign ra_odd0  = AW'(32'(row0) * HCOLS + 32'(c_odd));
    assign ra_odd1  = AW'(32'(row1) * HCOLS + 32'(c_odd));

    gn2d_ram #(
        .WIDTH (gn2d_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram_even (
        .i_clk     (i_clk),
        .i_we      (adv && wr_ok && !d_in.grid_col[0]),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (adv),
        .i_raddr_a (ra_even0),
        .i_raddr_b (ra_even1),
        .o_rdata_a (ev0),
        .o_rdata_b (ev1)
    );

    gn2d_ram #(
        .WIDTH (gn2d_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram_odd (
        .i_clk     (i_clk),
        .i_we      (adv && wr_ok && d_in.grid_col[0]),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (adv),
        .i_raddr_a (ra_odd0),
        .i_raddr_b (ra_odd1),
        .o_rdata_a (od0),
        .o_rdata_b (od1)
    );

    // ---------------- P1: RAM data, t*t and (3-2t) ----------------
    logic                        r_p1v;
    logic                        r_p1oog;
    logic                        r_p1par;
    logic [gn2d_pkg::FRAC_W-1:0] r_p1tx;
    logic [gn2d_pkg::FRAC_W-1:0] r_p1ty;
    logic [gn2d_pkg::TT_W-1:0]   r_p1ttx;
    logic [gn2d_pkg::TT_W-1:0]   r_p1tty;
    logic [gn2d_pkg::S_W-1:0]    r_p1sx;
    logic [gn2d_pkg::S_W-1:0]    r_p1sy;
    logic [gn2d_pkg::FRAC_W-1:0] d_tx;
    logic [gn2d_pkg::FRAC_W-1:0] d_ty;

    assign d_tx = r_dx[NDIV].dq[gn2d_pkg::FRAC_W-1:0];
    assign d_ty = r_dy[NDIV].dq[gn2d_pkg::FRAC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1oog <= d_oog;
            r_p1par <= ix[0];
            r_p1tx  <= d_tx;
            r_p1ty  <= d_ty;
            r_p1ttx <= gn2d_pkg::TT_W'(d_tx) * gn2d_pkg::TT_W'(d_tx);
            r_p1tty <= gn2d_pkg::TT_W'(d_ty) * gn2d_pkg::TT_W'(d_ty);
            r_p1sx  <= gn2d_pkg::THREE_Q16 - {1'b0, d_tx, 1'b0};
            r_p1sy  <= gn2d_pkg::THREE_Q16 - {1'b0, d_ty, 1'b0};
        end
    end

    // ---------------- P2: corner dots and weights ----------------
    logic [gn2d_pkg::ENTRY_W-1:0]       e00;
    logic [gn2d_pkg::ENTRY_W-1:0]       e10;
    logic [gn2d_pkg::ENTRY_W-1:0]       e01;
    logic [gn2d_pkg::ENTRY_W-1:0]       e11;
    logic signed [gn2d_pkg::OFS_W-1:0]  ox0;
    logic signed [gn2d_pkg::OFS_W-1:0]  ox1;
    logic signed [gn2d_pkg::OFS_W-1:0]  oy0;
    logic signed [gn2d_pkg::OFS_W-1:0]  oy1;
    logic                               r_p2v;
    logic                               r_p2oog;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_d00;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_d10;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_d01;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_d11;
    logic [gn2d_pkg::FRAC_W-1:0]        r_p2ux;
    logic [gn2d_pkg::FRAC_W-1:0]        r_p2uy;

    // odd cell index: left corner lives in the odd bank
    assign e00 = r_p1par ? od0 : ev0;
    assign e01 = r_p1par ? od1 : ev1;
    assign e10 = r_p1par ? ev0 : od0;
    assign e11 = r_p1par ? ev1 : od1;
    // offsets t and t-1 in Q.16
    assign ox0 = $signed({1'b0, r_p1tx});
    assign ox1 = $signed({1'b1, r_p1tx});
    assign oy0 = $signed({1'b0, r_p1ty});
    assign oy1 = $signed({1'b1, r_p1ty});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2oog <= r_p1oog;
            r_d00   <= gn2d_pkg::gn2d_dot(e00, ox0, oy0);
            r_d10   <= gn2d_pkg::gn2d_dot(e10, ox1, oy0);
            r_d01   <= gn2d_pkg::gn2d_dot(e01, ox0, oy1);
            r_d11   <= gn2d_pkg::gn2d_dot(e11, ox1, oy1);
            r_p2ux  <= gn2d_pkg::gn2d_weight(r_p1ttx, r_p1sx);
            r_p2uy  <= gn2d_pkg::gn2d_weight(r_p1tty, r_p1sy);
        end
    end

    // ---------------- P3/P4: blend along x ----------------
    logic                               r_p3v;
    logic                               r_p3oog;
    logic signed [gn2d_pkg::PROD_W-1:0] r_p3m0;
    logic signed [gn2d_pkg::PROD_W-1:0] r_p3m1;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_p3a0;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_p3a1;
    logic [gn2d_pkg::FRAC_W-1:0]        r_p3uy;
    logic                               r_p4v;
    logic                               r_p4oog;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_p4v0;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_p4v1;
    logic [gn2d_pkg::FRAC_W-1:0]        r_p4uy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3oog <= r_p2oog;
            r_p3m0  <= gn2d_pkg::gn2d_bmul(r_d00, r_d10, r_p2ux);
            r_p3m1  <= gn2d_pkg::gn2d_bmul(r_d01, r_d11, r_p2ux);
            r_p3a0  <= r_d00;
            r_p3a1  <= r_d01;
            r_p3uy  <= r_p2uy;
            r_p4oog <= r_p3oog;
            r_p4v0  <= gn2d_pkg::gn2d_bsum(r_p3a0, r_p3m0);
            r_p4v1  <= gn2d_pkg::gn2d_bsum(r_p3a1, r_p3m1);
            r_p4uy  <= r_p3uy;
        end
    end

    // ---------------- P5/P6: blend along y ----------------
    logic                               r_p5v;
    logic                               r_p5oog;
    logic signed [gn2d_pkg::PROD_W-1:0] r_p5m;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_p5a;
    logic                               r_p6v;
    logic                               r_p6oog;
    logic signed [gn2d_pkg::DOT_W-1:0]  r_p6val;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p5oog <= r_p4oog;
            r_p5m   <= gn2d_pkg::gn2d_bmul(r_p4v0, r_p4v1, r_p4uy);
            r_p5a   <= r_p4v0;
            r_p6oog <= r_p5oog;
            r_p6val <= gn2d_pkg::gn2d_bsum(r_p5a, r_p5m);
        end
    end

    // valid bits of the tail: only pixel transactions carry on past the RAMs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_p3v <= 1'b0;
            r_p4v <= 1'b0;
            r_p5v <= 1'b0;
            r_p6v <= 1'b0;
        end else if (adv) begin
            r_p1v <= r_dv[NDIV] && (d_in.mode == gn2d_pkg::MODE_PIXEL);
            r_p2v <= r_p1v;
            r_p3v <= r_p2v;
            r_p4v <= r_p3v;
            r_p5v <= r_p4v;
            r_p6v <= r_p5v;
        end
    end

    // ---------------- output register and skid ----------------
    gn2d_pkg::t_out fin_data;
    gn2d_pkg::t_out r_out;
    gn2d_pkg::t_out r_sk;
    logic           take;

    assign fin_data = gn2d_pkg::gn2d_result(r_p6val, r_p6oog);
    assign take     = r_ov && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (take || !r_ov) begin
            if (r_skv) begin
                r_ov  <= 1'b1;
                r_skv <= 1'b0;
            end else begin
                r_ov <= r_p6v;
            end
        end else if (r_p6v && adv) begin
            r_skv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_ov) begin
            r_out <= r_skv ? r_sk : fin_data;
        end else if (r_p6v && adv) begin
            r_sk <= fin_data;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    `GN2D_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skv, r_ov, "skid full with empty output")
    `GN2D_ASSERT_IMP(a_oog_zero, i_clk, i_rst_n, o_out_valid && o_out_data.out_of_grid, o_out_data.noise_value == '0, "flagged result not zero")
    `GN2D_ASSERT_NXT(a_skid_fill, i_clk, i_rst_n, !r_skv && r_p6v && r_ov && !i_out_ready, r_skv, "stalled result not caught by skid")

endmodule

// ===== bench/tb_gradient_noise_2d_core.sv =====
// Self-checking bench for gradient_noise_2d_core: gradient writes and noise
// evaluation checked against an in-bench fixed-point predictor.
// Depends on gn2d_pkg and the gradient_noise_2d_core RTL.
module tb_gradient_noise_2d_core;

    localparam int COLS        = 64;
    localparam int ROWS        = 64;
    localparam int FILL        = 16;   // corner block of the table that is filled
    localparam int DRAIN_CYCLES = 60;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    gn2d_pkg::t_in  i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    gn2d_pkg::t_out o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [gn2d_pkg::CS_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [31:0]     grad_store [COLS*ROWS];
    bit              grad_written [COLS*ROWS];
    logic [gn2d_pkg::CS_W-1:0] cur_cell_size;
    gn2d_pkg::t_out  noise_expected [$];
    int              mismatch_count = 0;
    bit              stall_enable = 1'b1;

    always #1 i_clk = ~i_clk;

    gradient_noise_2d_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $time);
        mismatch_count++;
    endtask

    function automatic longint floor_div_pow2(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint smooth_weight(input longint t);
        longint unsigned p;
        p = longint'(t) * t * (3 * 65536 - 2 * t);
        return longint'(p >> 32);
    endfunction

    function automatic longint corner_dot(input int col, input int row,
                                          input longint ox, input longint oy);
        logic [31:0] e;
        e = grad_store[row*COLS + col];
        return longint'($signed(e[15:0])) * ox + longint'($signed(e[31:16])) * oy;
    endfunction

    function automatic longint lerp_q16(input longint a, input longint b, input longint u);
        return floor_div_pow2(a * (65536 - u) + b * u, 16);
    endfunction

    // Applies one transaction to the predictor; queues a result for pixels.
    function automatic void predict_noise(input gn2d_pkg::t_in it);
        int     cs, px, py, ix, iy;
        longint tx, ty, ux, uy, v0, v1, v, r;
        gn2d_pkg::t_out o;
        if (it.mode == gn2d_pkg::MODE_WRITE) begin
            grad_store[it.grid_row*COLS + it.grid_col] = {it.grad_y, it.grad_x};
            grad_written[it.grid_row*COLS + it.grid_col] = 1'b1;
            return;
        end
        cs = (cur_cell_size == 0) ? 1 : int'(cur_cell_size);
        px = it.pixel_x;
        py = it.pixel_y;
        ix = px / cs;
        iy = py / cs;
        o = '0;
        if (ix + 1 >= COLS || iy + 1 >= ROWS) begin
            o.out_of_grid = 1'b1;
        end else begin
            tx = (longint'(px % cs) << 16) / cs;
            ty = (longint'(py % cs) << 16) / cs;
            ux = smooth_weight(tx);
            uy = smooth_weight(ty);
            v0 = lerp_q16(corner_dot(ix, iy, tx, ty),
                          corner_dot(ix + 1, iy, tx - 65536, ty), ux);
            v1 = lerp_q16(corner_dot(ix, iy + 1, tx, ty - 65536),
                          corner_dot(ix + 1, iy + 1, tx - 65536, ty - 65536), ux);
            v = lerp_q16(v0, v1, uy);
            r = floor_div_pow2(v, 15) + 32768;
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
            o.noise_value = r[15:0];
        end
        noise_expected.insert(noise_expected.size(), o);
    endfunction

    // Pixel is legal if it is off the grid or all four corners it reads were written.
    function automatic bit corners_ready(input int px, input int py);
        int cs, ix, iy;
        cs = (cur_cell_size == 0) ? 1 : int'(cur_cell_size);
        ix = px / cs;
        iy = py / cs;
        if (ix + 1 >= COLS || iy + 1 >= ROWS) return 1'b1;
        return grad_written[iy*COLS+ix] && grad_written[iy*COLS+ix+1] &&
               grad_written[(iy+1)*COLS+ix] && grad_written[(iy+1)*COLS+ix+1];
    endfunction

    // Sends one transaction and holds valid until accepted.
    task automatic send_item(input gn2d_pkg::t_in it);
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_noise(it);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (noise_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cell_size(input int value);
        wait_drained();
        i_cfg_data  <= gn2d_pkg::CS_W'(value);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_cell_size = gn2d_pkg::CS_W'(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic gn2d_pkg::t_in grad_item(input int col, input int row,
                                                input int gx, input int gy);
        gn2d_pkg::t_in it;
        it = '0;
        it.mode = gn2d_pkg::MODE_WRITE;
        it.grid_col = col[5:0];
        it.grid_row = row[5:0];
        it.grad_x = gx[15:0];
        it.grad_y = gy[15:0];
        // pixel fields are don't-care on a write
        it.pixel_x = 12'($urandom);
        it.pixel_y = 12'($urandom);
        return it;
    endfunction

    function automatic gn2d_pkg::t_in pixel_item(input int px, input int py);
        gn2d_pkg::t_in it;
        it = '0;
        it.mode = gn2d_pkg::MODE_PIXEL;
        it.pixel_x = px[11:0];
        it.pixel_y = py[11:0];
        // write fields are don't-care on a pixel
        it.grid_col = 6'($urandom);
        it.grid_row = 6'($urandom);
        it.grad_x = 16'($urandom);
        it.grad_y = 16'($urandom);
        return it;
    endfunction

    function automatic int rand_grad();
        case ($urandom_range(0, 5))
            0: return 16384;
            1: return -16384;
            2: return $urandom_range(0, 65535) - 32768;  // beyond +-1.0, up to the full Q1.14 span
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    // Fill the corner block of the table; later pixels read only written corners or are off the grid.
    task automatic test_fill_table();
        for (int r = 0; r < FILL; r++)
            for (int c = 0; c < FILL; c++)
                send_item(grad_item(c, r, rand_grad(), rand_grad()));
    endtask

    task automatic test_directed();
        write_cell_size(1);
        send_item(grad_item(0, 0, 16384, -16384));
        send_item(grad_item(1, 0, -32768, 32767));
        send_item(grad_item(0, 1, 0, 0));
        send_item(grad_item(1, 1, 16384, 16384));
        send_item(pixel_item(0, 0));
        send_item(pixel_item(14, 14));
        send_item(pixel_item(63, 0));        // cell on the right grid edge
        send_item(pixel_item(0, 63));
        send_item(pixel_item(4095, 4095));
        write_cell_size(0);                  // zero behaves as one
        send_item(pixel_item(5, 7));
        send_item(pixel_item(63, 63));
        write_cell_size(4096);
        send_item(pixel_item(0, 0));
        send_item(pixel_item(4095, 4095));
        send_item(pixel_item(2048, 1));
        write_cell_size(8191);
        send_item(pixel_item(4095, 0));
        send_item(pixel_item(1234, 4000));
        write_cell_size(65);                 // 4095/65 = 63: just off the grid
        send_item(pixel_item(4095, 0));
        send_item(pixel_item(974, 900));
    endtask

    task automatic test_random_phase(input int cs_value, input int n_items);
        gn2d_pkg::t_in it;
        int  left;
        write_cell_size(cs_value);
        while (n_items > 0) begin
            left = $urandom_range(1, 40);
            while (left > 0 && n_items > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    it = grad_item($urandom_range(0, 63), $urandom_range(0, 63),
                                   rand_grad(), rand_grad());
                end else begin
                    it = pixel_item($urandom_range(0, 4095), $urandom_range(0, 4095));
                    if ($urandom_range(0, 1) ||
                        !corners_ready(int'(it.pixel_x), int'(it.pixel_y))) begin
                        // keep the pixel on cells with written corners
                        it.pixel_x = 12'($urandom_range(0, (FILL - 1) * cs_value - 1));
                        it.pixel_y = 12'($urandom_range(0, (FILL - 1) * cs_value - 1));
                    end
                end
                send_item(it);
                left--;
                n_items--;
            end
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 12));
            if ($urandom_range(0, 60) == 0) wait_drained();
        end
    endtask

    // Receiver: stall pattern of its own, sampled on the rising edge.
    always @(negedge i_clk) begin
        if (!stall_enable) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge i_clk) begin
        gn2d_pkg::t_out exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (noise_expected.size() == 0) begin
                report_mismatch("unexpected result", o_out_data, 0);
            end else begin
                exp = noise_expected.pop_front();
                if (o_out_data.noise_value !== exp.noise_value)
                    report_mismatch("noise_value", o_out_data.noise_value, exp.noise_value);
                if (o_out_data.out_of_grid !== exp.out_of_grid)
                    report_mismatch("out_of_grid", o_out_data.out_of_grid, exp.out_of_grid);
            end
        end
    end

    initial begin
        for (int k = 0; k < COLS*ROWS; k++) grad_written[k] = 1'b0;
        cur_cell_size = 1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        stall_enable = 1'b0;
        test_fill_table();
        stall_enable = 1'b1;
        test_directed();
        test_random_phase(1, 300);
        test_random_phase(7, 300);
        test_random_phase(64, 300);
        test_random_phase(3, 300);
        wait_drained();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
